// ===== sv/pinhole_projection_with_distortion_unit_assert.svh =====
// Assertion macros used by the checker of the projection unit.
// Both forms sample on the rising edge of aclk and are off during reset.
`ifndef PINHOLE_PROJECTION_WITH_DISTORTION_UNIT_ASSERT_SVH
`define PINHOLE_PROJECTION_WITH_DISTORTION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ppd_pkg.sv =====
`default_nettype none
package ppd_pkg;

    // Signed intermediate value, magnitude held within 2^62 - 1.
    typedef logic signed [63:0] val_t;

    // Right shift applied after a product.
    typedef enum logic [1:0] {
        SH14,
        SH15,
        SH24,
        SH28
    } shift_t;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic        front;
        logic [31:0] v;
        logic [31:0] u;
    } pix_t;

    // Configuration register indexes.
    localparam logic [7:0] REG_FOCAL_X    = 8'd0;
    localparam logic [7:0] REG_FOCAL_Y    = 8'd1;
    localparam logic [7:0] REG_CENTER_X   = 8'd2;
    localparam logic [7:0] REG_CENTER_Y   = 8'd3;
    localparam logic [7:0] REG_RADIAL_K1  = 8'd4;
    localparam logic [7:0] REG_RADIAL_K2  = 8'd5;
    localparam logic [7:0] REG_RADIAL_K3  = 8'd6;
    localparam logic [7:0] REG_TANGENTIAL = 8'd7;

    localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

    // Divider geometry: a 32-bit magnitude shifted up by 24 fraction bits.
    localparam int FRAC_SH  = 24;
    localparam int DIV_BITS = 32 + FRAC_SH;
    localparam int REM_W    = 31;
    localparam int DIV_LAT  = DIV_BITS + 1;

    // Multiplier: 31-bit halves of a 62-bit magnitude.
    localparam int HALF_W = 31;
    localparam int MAG_W  = 2 * HALF_W;
    localparam int PROD_W = 2 * MAG_W;

    // Alignment delays inside the distortion datapath.
    localparam int R2_DLY   = 5;
    localparam int RAD_DLY  = 4;
    localparam int XY_DLY   = 22;
    localparam int P1XY_DLY = 17;
    localparam int P2SX_DLY = 16;
    localparam int P1SY_DLY = 15;
    localparam int P2XY_DLY = 18;

    // Stages from the input register to the pixel register, inclusive.
    localparam int PIPE_LAT = DIV_LAT + 36;

    localparam val_t MAG_CAP  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam val_t ONE_Q24  = 64'sh0000_0000_0100_0000;
    localparam val_t I32_MAX  = 64'sd2147483647;
    localparam val_t I32_MIN  = -64'sd2147483648;
    localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF_0000;

    // Sum whose magnitude saturates at 2^62 - 1.
    function automatic val_t sat_add(input val_t a, input val_t b);
        logic signed [64:0] s;
        logic signed [64:0] cap;
        s   = {a[63], a} + {b[63], b};
        cap = {1'b0, MAG_CAP};
        if (s > cap) begin
            return MAG_CAP;
        end else if (s < -cap) begin
            return -MAG_CAP;
        end
        return s[63:0];
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic [31:0] clamp32(input val_t v);
        if (v > I32_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (v < I32_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/pinhole_projection_with_distortion_unit.sv =====
// Pinhole projection with Brown-Conrady distortion. Each transfer on the s_ side carries
// one camera-frame point in Q16.16 and produces exactly one pixel transfer on the m_
// side, in order. The unit takes one point per clock while s_tready is high; each point
// passes through the 56-step restoring dividers that form X/Z and Y/Z and then through
// the chain of five-stage multipliers behind them on its way to m_tdata. A two-entry
// output queue lets the pipeline keep accepting while one result waits; s_tready drops
// only when both entries are full. Points with depth at or below zero come out as
// (-1.0, -1.0) with m_tuser low. Write the intrinsics through the cfg_ channel only
// while no point is in flight.
`default_nettype none
module pinhole_projection_with_distortion_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Point input. s_tdata: point_x [31:0], point_y [63:32], point_z [95:64].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,
    // Pixel output. m_tdata: pixel_u [31:0], pixel_v [63:32]. m_tuser: in_front [0].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    output logic [0:0]       m_tuser,
    // Register writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import ppd_pkg::*;

    // Configuration registers.
    logic [31:0] focal_x_reg;
    logic [31:0] focal_y_reg;
    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [31:0] radial_k1_reg;
    logic [31:0] radial_k2_reg;
    logic [31:0] radial_k3_reg;
    logic [31:0] tangential_reg;

    val_t fx_v, fy_v, cx_v, cy_v, k1_v, k2_v, k3_v, p1_v, p2_v;

    logic en;

    // Stage control and input registers.
    logic               vld_reg [PIPE_LAT];
    logic               beh_reg [PIPE_LAT];
    logic signed [31:0] pt_x_reg;
    logic signed [31:0] pt_y_reg;
    logic signed [31:0] pt_z_reg;

    // Datapath values.
    val_t x_q, y_q, x2, y2, xy;
    val_t r2_reg, tx_reg, ty_reg, sx_reg, sy_reg;
    val_t r4, r6, k1r2, k2r4, k3r6;
    val_t rad_a_reg, rad_b_reg, rad_c_reg;
    val_t xd0, yd0, p1xy, p2sx, p1sy, p2xy;
    val_t xd1_reg, xd_reg, yd1_reg, yd_reg;
    val_t u0, v0;
    logic [31:0] u_reg, v_reg;

    // Alignment delay lines.
    val_t r2_dly_reg   [R2_DLY];
    val_t rad_a_dly_reg [RAD_DLY];
    val_t rad_b_dly_reg [RAD_DLY];
    val_t x_dly_reg    [XY_DLY];
    val_t y_dly_reg    [XY_DLY];
    val_t p1xy_dly_reg [P1XY_DLY];
    val_t p2sx_dly_reg [P2SX_DLY];
    val_t p1sy_dly_reg [P1SY_DLY];
    val_t p2xy_dly_reg [P2XY_DLY];

    // Output queue.
    pix_t       q_head_reg, q_head_next;
    pix_t       q_tail_reg, q_tail_next;
    logic [1:0] q_cnt_reg, q_cnt_next;
    pix_t       pix_in;
    logic       push;
    logic       pop;

    // Register writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg    <= FOCAL_RESET;
            focal_y_reg    <= FOCAL_RESET;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radial_k1_reg  <= '0;
            radial_k2_reg  <= '0;
            radial_k3_reg  <= '0;
            tangential_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FOCAL_X:    focal_x_reg    <= cfg_data;
                REG_FOCAL_Y:    focal_y_reg    <= cfg_data;
                REG_CENTER_X:   center_x_reg   <= cfg_data;
                REG_CENTER_Y:   center_y_reg   <= cfg_data;
                REG_RADIAL_K1:  radial_k1_reg  <= cfg_data;
                REG_RADIAL_K2:  radial_k2_reg  <= cfg_data;
                REG_RADIAL_K3:  radial_k3_reg  <= cfg_data;
                REG_TANGENTIAL: tangential_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fx_v = val_t'({32'b0, focal_x_reg});
    assign fy_v = val_t'({32'b0, focal_y_reg});
    assign cx_v = val_t'($signed(center_x_reg));
    assign cy_v = val_t'($signed(center_y_reg));
    assign k1_v = val_t'($signed(radial_k1_reg));
    assign k2_v = val_t'($signed(radial_k2_reg));
    assign k3_v = val_t'($signed(radial_k3_reg));
    assign p1_v = val_t'($signed(tangential_reg[15:0]));
    assign p2_v = val_t'($signed(tangential_reg[31:16]));

    // The whole pipeline moves while the output queue has room.
    assign en       = (q_cnt_reg != 2'd2);
    assign s_tready = en;

    // Input registers and the valid and behind-camera flags that follow each point.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_x_reg   <= s_tdata[31:0];
            pt_y_reg   <= s_tdata[63:32];
            pt_z_reg   <= s_tdata[95:64];
            beh_reg[0] <= ($signed(s_tdata[95:64]) <= 32'sd0);
            for (int i = 1; i < PIPE_LAT; i++) begin
                beh_reg[i] <= beh_reg[i-1];
            end
        end
    end

    // Normalized coordinates in Q.24.
    ppd_div u_div_x (.aclk(aclk), .en(en), .num(pt_x_reg), .den(pt_z_reg[30:0]), .quo(x_q));
    ppd_div u_div_y (.aclk(aclk), .en(en), .num(pt_y_reg), .den(pt_z_reg[30:0]), .quo(y_q));

    // Squares and cross product.
    ppd_mul u_mul_x2 (.aclk(aclk), .en(en), .a(x_q), .b(x_q), .sh(SH24), .p(x2));
    ppd_mul u_mul_y2 (.aclk(aclk), .en(en), .a(y_q), .b(y_q), .sh(SH24), .p(y2));
    ppd_mul u_mul_xy (.aclk(aclk), .en(en), .a(x_q), .b(y_q), .sh(SH24), .p(xy));

    // Radius squared and the tangential sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg <= sat_add(x2, y2);
            tx_reg <= sat_add(x2, x2);
            ty_reg <= sat_add(y2, y2);
            sx_reg <= sat_add(r2_reg, tx_reg);
            sy_reg <= sat_add(r2_reg, ty_reg);
        end
    end

    // Higher radius powers.
    ppd_mul u_mul_r4 (.aclk(aclk), .en(en), .a(r2_reg), .b(r2_reg), .sh(SH24), .p(r4));
    ppd_mul u_mul_r6 (.aclk(aclk), .en(en), .a(r4), .b(r2_dly_reg[R2_DLY-1]), .sh(SH24),
                      .p(r6));

    // Radial factor, accumulated in model order.
    ppd_mul u_mul_k1 (.aclk(aclk), .en(en), .a(k1_v), .b(r2_reg), .sh(SH28), .p(k1r2));
    ppd_mul u_mul_k2 (.aclk(aclk), .en(en), .a(k2_v), .b(r4), .sh(SH28), .p(k2r4));
    ppd_mul u_mul_k3 (.aclk(aclk), .en(en), .a(k3_v), .b(r6), .sh(SH28), .p(k3r6));

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_a_reg <= sat_add(ONE_Q24, k1r2);
            rad_b_reg <= sat_add(rad_a_dly_reg[RAD_DLY-1], k2r4);
            rad_c_reg <= sat_add(rad_b_dly_reg[RAD_DLY-1], k3r6);
        end
    end

    // Tangential products.
    ppd_mul u_mul_p1xy (.aclk(aclk), .en(en), .a(p1_v), .b(xy), .sh(SH14), .p(p1xy));
    ppd_mul u_mul_p2sx (.aclk(aclk), .en(en), .a(p2_v), .b(sx_reg), .sh(SH15), .p(p2sx));
    ppd_mul u_mul_p1sy (.aclk(aclk), .en(en), .a(p1_v), .b(sy_reg), .sh(SH15), .p(p1sy));
    ppd_mul u_mul_p2xy (.aclk(aclk), .en(en), .a(p2_v), .b(xy), .sh(SH14), .p(p2xy));

    // Radially scaled coordinates.
    ppd_mul u_mul_xr (.aclk(aclk), .en(en), .a(x_dly_reg[XY_DLY-1]), .b(rad_c_reg),
                      .sh(SH24), .p(xd0));
    ppd_mul u_mul_yr (.aclk(aclk), .en(en), .a(y_dly_reg[XY_DLY-1]), .b(rad_c_reg),
                      .sh(SH24), .p(yd0));

    // Delay lines that line operands up with their partners.
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_dly_reg[0]    <= r2_reg;
            rad_a_dly_reg[0] <= rad_a_reg;
            rad_b_dly_reg[0] <= rad_b_reg;
            x_dly_reg[0]     <= x_q;
            y_dly_reg[0]     <= y_q;
            p1xy_dly_reg[0]  <= p1xy;
            p2sx_dly_reg[0]  <= p2sx;
            p1sy_dly_reg[0]  <= p1sy;
            p2xy_dly_reg[0]  <= p2xy;
            for (int i = 1; i < R2_DLY; i++) begin
                r2_dly_reg[i] <= r2_dly_reg[i-1];
            end
            for (int i = 1; i < RAD_DLY; i++) begin
                rad_a_dly_reg[i] <= rad_a_dly_reg[i-1];
                rad_b_dly_reg[i] <= rad_b_dly_reg[i-1];
            end
            for (int i = 1; i < XY_DLY; i++) begin
                x_dly_reg[i] <= x_dly_reg[i-1];
                y_dly_reg[i] <= y_dly_reg[i-1];
            end
            for (int i = 1; i < P1XY_DLY; i++) begin
                p1xy_dly_reg[i] <= p1xy_dly_reg[i-1];
            end
            for (int i = 1; i < P2SX_DLY; i++) begin
                p2sx_dly_reg[i] <= p2sx_dly_reg[i-1];
            end
            for (int i = 1; i < P1SY_DLY; i++) begin
                p1sy_dly_reg[i] <= p1sy_dly_reg[i-1];
            end
            for (int i = 1; i < P2XY_DLY; i++) begin
                p2xy_dly_reg[i] <= p2xy_dly_reg[i-1];
            end
        end
    end

    // Distorted coordinates.
    always_ff @(posedge aclk) begin
        if (en) begin
            xd1_reg <= sat_add(xd0, p1xy_dly_reg[P1XY_DLY-1]);
            xd_reg  <= sat_add(xd1_reg, p2sx_dly_reg[P2SX_DLY-1]);
            yd1_reg <= sat_add(yd0, p1sy_dly_reg[P1SY_DLY-1]);
            yd_reg  <= sat_add(yd1_reg, p2xy_dly_reg[P2XY_DLY-1]);
        end
    end

    // Focal scaling and principal point.
    ppd_mul u_mul_u (.aclk(aclk), .en(en), .a(fx_v), .b(xd_reg), .sh(SH24), .p(u0));
    ppd_mul u_mul_v (.aclk(aclk), .en(en), .a(fy_v), .b(yd_reg), .sh(SH24), .p(v0));

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg <= clamp32(sat_add(u0, cx_v));
            v_reg <= clamp32(sat_add(v0, cy_v));
        end
    end

    // Points behind the camera take the fixed marker result.
    always_comb begin
        pix_in.front = !beh_reg[PIPE_LAT-1];
        pix_in.u     = beh_reg[PIPE_LAT-1] ? MINUS_ONE_Q16 : u_reg;
        pix_in.v     = beh_reg[PIPE_LAT-1] ? MINUS_ONE_Q16 : v_reg;
    end

    // Two-entry output queue: the head drives the m_ ports.
    assign push = en && vld_reg[PIPE_LAT-1];
    assign pop  = (q_cnt_reg != 2'd0) && m_tready;

    always_comb begin
        q_head_next = q_head_reg;
        q_tail_next = q_tail_reg;
        q_cnt_next  = q_cnt_reg;
        unique case (q_cnt_reg)
            2'd0: begin
                if (push) begin
                    q_head_next = pix_in;
                    q_cnt_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    q_head_next = pix_in;
                end else if (push) begin
                    q_tail_next = pix_in;
                    q_cnt_next  = 2'd2;
                end else if (pop) begin
                    q_cnt_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    q_head_next = q_tail_reg;
                    q_cnt_next  = 2'd1;
                end
            end
            default: q_cnt_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= 2'd0;
        end else begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_head_reg <= q_head_next;
        q_tail_reg <= q_tail_next;
    end

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = {q_head_reg.v, q_head_reg.u};
    assign m_tuser  = q_head_reg.front;

endmodule
`default_nettype wire

// ===== sv/ppd_div.sv =====
`default_nettype none
module ppd_div (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [31:0] num,
    input  wire logic [30:0]        den,
    output ppd_pkg::val_t           quo
);
    import ppd_pkg::*;

    logic [31:0] num_mag;

    logic [REM_W-1:0]    rem_reg [DIV_BITS];
    logic [DIV_BITS-1:0] n_reg   [DIV_BITS];
    logic [REM_W-1:0]    den_reg [DIV_BITS];
    logic                neg_reg [DIV_BITS];
    val_t                quo_reg;
    val_t                quo_mag;

    // Magnitude of the numerator; the quotient takes its sign at the end.
    assign num_mag = num[31] ? 32'(-num) : 32'(num);

    // One restoring step per stage: bring down one dividend bit, subtract if it fits.
    genvar k;
    for (k = 0; k < DIV_BITS; k++) begin : g_step
        logic [REM_W-1:0]    rem_in;
        logic [DIV_BITS-1:0] n_in;
        logic [REM_W-1:0]    den_in;
        logic                neg_in;
        logic [REM_W:0]      t;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign n_in   = {num_mag, {FRAC_SH{1'b0}}};
            assign den_in = den;
            assign neg_in = num[31];
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign n_in   = n_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign t  = {rem_in, n_in[DIV_BITS-1]};
        assign ge = t >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? REM_W'(t - {1'b0, den_in}) : t[REM_W-1:0];
                n_reg[k]   <= {n_in[DIV_BITS-2:0], ge};
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    // Apply the sign to the quotient.
    assign quo_mag = val_t'({{(64 - DIV_BITS){1'b0}}, n_reg[DIV_BITS-1]});

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= neg_reg[DIV_BITS-1] ? -quo_mag : quo_mag;
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

// ===== sv/ppd_mul.sv =====
`default_nettype none
module ppd_mul (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire ppd_pkg::val_t   a,
    input  wire ppd_pkg::val_t   b,
    input  wire ppd_pkg::shift_t sh,
    output ppd_pkg::val_t        p
);
    import ppd_pkg::*;

    val_t              a_abs;
    val_t              b_abs;
    logic [MAG_W-1:0]  ma_reg;
    logic [MAG_W-1:0]  mb_reg;
    logic              neg1_reg;
    logic [MAG_W-1:0]  p00_reg;
    logic [MAG_W-1:0]  p01_reg;
    logic [MAG_W-1:0]  p10_reg;
    logic [MAG_W-1:0]  p11_reg;
    logic              neg2_reg;
    logic [MAG_W:0]    mid_reg;
    logic [MAG_W-1:0]  lo3_reg;
    logic [MAG_W-1:0]  hi3_reg;
    logic              neg3_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg4_reg;
    logic [PROD_W-1:0] shf;
    val_t              mag_sat;
    val_t              p_reg;

    assign a_abs = a[63] ? -a : a;
    assign b_abs = b[63] ? -b : b;

    // Operand magnitudes and the product sign.
    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= a_abs[MAG_W-1:0];
            mb_reg   <= b_abs[MAG_W-1:0];
            neg1_reg <= a[63] ^ b[63];
        end
    end

    // Four 31 by 31 partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg  <= ma_reg[HALF_W-1:0] * mb_reg[HALF_W-1:0];
            p01_reg  <= ma_reg[HALF_W-1:0] * mb_reg[MAG_W-1:HALF_W];
            p10_reg  <= ma_reg[MAG_W-1:HALF_W] * mb_reg[HALF_W-1:0];
            p11_reg  <= ma_reg[MAG_W-1:HALF_W] * mb_reg[MAG_W-1:HALF_W];
            neg2_reg <= neg1_reg;
        end
    end

    // Sum of the cross terms.
    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg  <= {1'b0, p01_reg} + {1'b0, p10_reg};
            lo3_reg  <= p00_reg;
            hi3_reg  <= p11_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // Full product: the outer terms do not overlap, the cross terms add in the middle.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= {hi3_reg, lo3_reg}
                      + ({{(PROD_W - MAG_W - 1){1'b0}}, mid_reg} << HALF_W);
            neg4_reg <= neg3_reg;
        end
    end

    // Shift toward zero, saturate the magnitude, restore the sign.
    always_comb begin
        unique case (sh)
            SH14:    shf = prod_reg >> 14;
            SH15:    shf = prod_reg >> 15;
            SH24:    shf = prod_reg >> 24;
            SH28:    shf = prod_reg >> 28;
            default: shf = prod_reg >> 24;
        endcase
        if (|shf[PROD_W-1:MAG_W]) begin
            mag_sat = MAG_CAP;
        end else begin
            mag_sat = val_t'({2'b00, shf[MAG_W-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= neg4_reg ? -mag_sat : mag_sat;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== sv/ppd_checker.sv =====
`default_nettype none
`include "pinhole_projection_with_distortion_unit_assert.svh"
module ppd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A result that is not taken stays offered.
    `PPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")

    // A stalled result keeps its payload.
    `PPD_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "m_ payload changed while stalled")

    // Input is refused only while results wait at the output.
    `PPD_ASSERT_NOW(a_ready_backpressure, !s_tready, m_tvalid, "s_tready low with nothing to deliver")

    // A point behind the camera reports minus one on both axes.
    `PPD_ASSERT_NOW(a_behind_marker, m_tvalid && !m_tuser[0], m_tdata == 64'hFFFF_0000_FFFF_0000, "behind-camera result is not the marker")

endmodule

bind pinhole_projection_with_distortion_unit ppd_checker u_ppd_checker (.*);
`default_nettype wire

// ===== tb/pinhole_projection_with_distortion_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module pinhole_projection_with_distortion_unit_tb;
    import ppd_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;      // point_x [31:0], point_y [63:32], point_z [95:64]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // pixel_u [31:0], pixel_v [63:32]
    logic [0:0]  m_tuser;           // in_front [0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Shadow copy of the intrinsics, indexed by register number.
    logic [31:0] intrinsics [0:7];

    logic [95:0] pending_points [$];
    pix_t        expected_pixels [$];
    int          points_queued = 0;
    int          points_taken = 0;
    int          mismatches = 0;
    bit          point_took = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    localparam longint CAP = 64'sh3FFF_FFFF_FFFF_FFFF;

    pinhole_projection_with_distortion_unit u_top (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Exact product, truncated shift toward zero, magnitude capped.
    function automatic longint mul_shift(input longint a, input longint b, input int sh);
        logic [127:0] prod;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  q;
        bit           neg;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = {64'b0, ma} * {64'b0, mb};
        prod = prod >> sh;
        q    = (prod > CAP) ? CAP : prod[63:0];
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint cap_sum(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > CAP) begin
            return CAP;
        end else if (s < -CAP) begin
            return -CAP;
        end
        return s;
    endfunction

    function automatic longint div_q24(input longint num, input longint den);
        logic [63:0] q;
        logic [63:0] mn;
        mn = (num < 0) ? -num : num;
        q  = (mn << 24) / den;
        if (q > CAP) begin
            q = CAP;
        end
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] to_pixel(input logic [31:0] focal, input longint d,
                                             input logic [31:0] center);
        longint p;
        p = cap_sum(mul_shift(longint'({32'b0, focal}), d, 24),
                    longint'($signed(center)));
        if (p > 64'sd2147483647) begin
            p = 64'sd2147483647;
        end else if (p < -64'sd2147483648) begin
            p = -64'sd2147483648;
        end
        return p[31:0];
    endfunction

    // Projects one camera-frame point with the current intrinsics.
    function automatic pix_t project_point(input logic [95:0] pt);
        pix_t   r;
        longint px, py, pz, x, y, x2, y2, xy, r2, r4, r6, radial, p1, p2, xd, yd;
        px = longint'($signed(pt[31:0]));
        py = longint'($signed(pt[63:32]));
        pz = longint'($signed(pt[95:64]));
        if (pz <= 0) begin
            r.u     = MINUS_ONE_Q16;
            r.v     = MINUS_ONE_Q16;
            r.front = 1'b0;
            return r;
        end
        x  = div_q24(px, pz);
        y  = div_q24(py, pz);
        x2 = mul_shift(x, x, 24);
        y2 = mul_shift(y, y, 24);
        xy = mul_shift(x, y, 24);
        r2 = cap_sum(x2, y2);
        r4 = mul_shift(r2, r2, 24);
        r6 = mul_shift(r4, r2, 24);
        radial = 64'sd1 << 24;
        radial = cap_sum(radial, mul_shift(longint'($signed(intrinsics[REG_RADIAL_K1])), r2, 28));
        radial = cap_sum(radial, mul_shift(longint'($signed(intrinsics[REG_RADIAL_K2])), r4, 28));
        radial = cap_sum(radial, mul_shift(longint'($signed(intrinsics[REG_RADIAL_K3])), r6, 28));
        p1 = longint'($signed(intrinsics[REG_TANGENTIAL][15:0]));
        p2 = longint'($signed(intrinsics[REG_TANGENTIAL][31:16]));
        xd = mul_shift(x, radial, 24);
        xd = cap_sum(xd, mul_shift(p1, xy, 14));
        xd = cap_sum(xd, mul_shift(p2, cap_sum(r2, cap_sum(x2, x2)), 15));
        yd = mul_shift(y, radial, 24);
        yd = cap_sum(yd, mul_shift(p1, cap_sum(r2, cap_sum(y2, y2)), 15));
        yd = cap_sum(yd, mul_shift(p2, xy, 14));
        r.u     = to_pixel(intrinsics[REG_FOCAL_X], xd, intrinsics[REG_CENTER_X]);
        r.v     = to_pixel(intrinsics[REG_FOCAL_Y], yd, intrinsics[REG_CENTER_Y]);
        r.front = 1'b1;
        return r;
    endfunction

    // Mostly plausible scenes, some raw noise and some points behind the camera.
    function automatic logic [95:0] random_point();
        logic [31:0] x, y, z;
        int          kind;
        kind = $urandom_range(0, 9);
        x = $urandom;
        y = $urandom;
        z = $urandom;
        if (kind == 0) begin
            z = (z == 0) ? z : -($urandom_range(0, 32'h7FFF_FFFF));
        end else if (kind >= 3) begin
            z = $urandom_range(32'h0000_1000, 32'h0100_0000);
            x = $signed(x) >>> $urandom_range(6, 24);
            y = $signed(y) >>> $urandom_range(6, 24);
        end
        return {z, y, x};
    endfunction

    task automatic queue_point(input logic [95:0] pt);
        pending_points.push_back(pt);
        points_queued++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_TANGENTIAL) begin
            intrinsics[idx[2:0]] = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) queue_point(random_point());
        wait (points_taken == points_queued && expected_pixels.size() == 0);
        repeat (150) @(posedge aclk);
    endtask

    // Point sender.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || point_took)) begin
            if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= pending_points.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Pixel receiver, with an optional long hold-off.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Predict on each point transfer, check each pixel transfer.
    always @(posedge aclk) begin
        pix_t want;
        point_took = s_tvalid && s_tready;
        if (point_took) begin
            expected_pixels.push_back(project_point(s_tdata));
            points_taken++;
        end
        if (m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel transfer %h/%b", $time, m_tdata, m_tuser);
            end else begin
                want = expected_pixels.pop_front();
                if (want.u !== m_tdata[31:0] || want.v !== m_tdata[63:32]
                        || want.front !== m_tuser[0]) begin
                    mismatches++;
                    $display("%0t: pixel mismatch expected u=%h v=%h front=%b, got u=%h v=%h front=%b",
                             $time, want.u, want.v, want.front,
                             m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
                end
            end
        end
    end

    initial begin
        intrinsics[REG_FOCAL_X]    = FOCAL_RESET;
        intrinsics[REG_FOCAL_Y]    = FOCAL_RESET;
        intrinsics[REG_CENTER_X]   = '0;
        intrinsics[REG_CENTER_Y]   = '0;
        intrinsics[REG_RADIAL_K1]  = '0;
        intrinsics[REG_RADIAL_K2]  = '0;
        intrinsics[REG_RADIAL_K3]  = '0;
        intrinsics[REG_TANGENTIAL] = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed points under reset intrinsics: depth edges and extreme ratios.
        queue_point({32'h0000_0000, 32'h0001_0000, 32'h0001_0000});
        queue_point({32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000});
        queue_point({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        queue_point({32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
        queue_point({32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        queue_point({32'h0000_0001, 32'h8000_0000, 32'h8000_0000});
        queue_point({32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000});
        queue_point({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
        queue_point({32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF});
        queue_point({32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
        queue_point({32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000});
        run_random(10);

        // Typical camera: 500 px and 498.5 px focal, centered, mild barrel distortion.
        write_reg(REG_FOCAL_X, 32'h01F4_0000);
        write_reg(REG_FOCAL_Y, 32'h01F2_8000);
        write_reg(REG_CENTER_X, 32'h0140_0000);
        write_reg(REG_CENTER_Y, 32'h00F0_0000);
        write_reg(REG_RADIAL_K1, 32'hFC00_0000);
        write_reg(REG_RADIAL_K2, 32'h0080_0000);
        write_reg(REG_RADIAL_K3, 32'hFFF0_0000);
        write_reg(REG_TANGENTIAL, 32'h0010_FFE0);
        write_reg(8'd8, 32'hDEAD_BEEF);
        send_idle_pct = 46;
        run_random(130);

        // Largest coefficients; the receiver holds off to fill the unit.
        write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
        write_reg(REG_FOCAL_Y, 32'hFFFF_FFFF);
        write_reg(REG_CENTER_X, 32'h8000_0000);
        write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
        write_reg(REG_RADIAL_K1, 32'h7FFF_FFFF);
        write_reg(REG_RADIAL_K2, 32'h8000_0000);
        write_reg(REG_RADIAL_K3, 32'h7FFF_FFFF);
        write_reg(REG_TANGENTIAL, 32'h7FFF_8000);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        hold_req       = 1'b1;
        run_random(120);

        // Zero focal lengths and the opposite coefficient extremes.
        write_reg(REG_FOCAL_X, 32'h0000_0000);
        write_reg(REG_FOCAL_Y, 32'h0000_0000);
        write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_RADIAL_K1, 32'h8000_0000);
        write_reg(REG_RADIAL_K2, 32'h7FFF_FFFF);
        write_reg(REG_RADIAL_K3, 32'h8000_0000);
        write_reg(REG_TANGENTIAL, 32'h8000_7FFF);
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        run_random(100);

        // Random intrinsics.
        for (int i = 0; i <= REG_TANGENTIAL; i++) begin
            write_reg(i[7:0], $urandom);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(130);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ===== pinhole_projection_with_distortion_unit.f =====
+incdir+sv
sv/ppd_pkg.sv
sv/ppd_div.sv
sv/ppd_mul.sv
sv/pinhole_projection_with_distortion_unit.sv
sv/ppd_checker.sv
tb/pinhole_projection_with_distortion_unit_tb.sv
